FILE: rtl/eng_pkg.sv
package eng_pkg;

   // Sample and fixed-point widths
   localparam int SAMPLE_W = 24;
   localparam int Q_W      = 24;                 // coefficient fraction bits
   localparam int COEF_W   = 24;
   localparam int GAIN_W   = 19;                 // Q3.16 gain target
   localparam int TH_W     = 23;
   localparam int GG_W     = Q_W + 1;            // gate gain, Q1.24
   localparam int SG_W     = 27;                 // smoothed gain, Q3.24
   localparam int ENV_W    = SAMPLE_W + Q_W;     // envelope, sample LSBs times 2^24
   localparam int CMP_W    = (ENV_W > TH_W + Q_W) ? ENV_W : TH_W + Q_W;
   localparam int PROD_W   = SAMPLE_W + 3;       // sample times gains, before saturation

   // Shared radix-4 serial multiplier
   localparam int MUL_A_W    = ENV_W;
   localparam int MUL_B_MAX  = (SAMPLE_W > GG_W) ? SAMPLE_W : GG_W;
   localparam int MUL_B_W    = ((MUL_B_MAX + 1) / 2) * 2;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_DIGITS = MUL_B_W / 2;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_TARGET     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_OPEN_THRESHOLD  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_CLOSE_THRESHOLD = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_COEF     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_COEF    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_GATE_OPEN_RATE  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_GATE_CLOSE_RATE = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_SMOOTH     = CSR_IDX_W'(7);

   // Register reset values
   localparam logic [GAIN_W-1:0] RST_GAIN_TARGET     = GAIN_W'(65536);
   localparam logic [TH_W-1:0]   RST_OPEN_THRESHOLD  = TH_W'(8389);
   localparam logic [TH_W-1:0]   RST_CLOSE_THRESHOLD = TH_W'(4194);
   localparam logic [COEF_W-1:0] RST_ATTACK_COEF     = COEF_W'(838861);
   localparam logic [COEF_W-1:0] RST_RELEASE_COEF    = COEF_W'(3355);
   localparam logic [COEF_W-1:0] RST_GATE_OPEN_RATE  = COEF_W'(838861);
   localparam logic [COEF_W-1:0] RST_GATE_CLOSE_RATE = COEF_W'(16777);
   localparam logic [COEF_W-1:0] RST_GAIN_SMOOTH     = COEF_W'(33554);

   // Fixed-point one and saturation limits
   localparam logic [ENV_W-1:0]    ENV_ONE     = ENV_W'(1) << Q_W;
   localparam logic [GG_W-1:0]     GG_ONE      = GG_W'(1) << Q_W;
   localparam logic [SG_W-1:0]     SG_ONE      = SG_W'(1) << Q_W;
   localparam logic [PROD_W-1:0]   NEG_LIM_MAG = PROD_W'(1) << (SAMPLE_W - 1);
   localparam logic [PROD_W-1:0]   POS_LIM_MAG = NEG_LIM_MAG - PROD_W'(1);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef struct packed {
      logic [GAIN_W-1:0] gain_target;
      logic [TH_W-1:0]   open_threshold;
      logic [TH_W-1:0]   close_threshold;
      logic [COEF_W-1:0] attack_coef;
      logic [COEF_W-1:0] release_coef;
      logic [COEF_W-1:0] gate_open_rate;
      logic [COEF_W-1:0] gate_close_rate;
      logic [COEF_W-1:0] gain_smooth_rate;
   } cfg_type;

endpackage

FILE: rtl/eng_if.sv
// Sample input channel
interface eng_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [eng_pkg::SAMPLE_W-1:0]  sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// Result channel
interface eng_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [eng_pkg::SAMPLE_W-1:0]  sample_out;
   logic                                 gate_is_open;

   modport source (output valid, output sample_out, output gate_is_open, input ready);
   modport sink   (input valid, input sample_out, input gate_is_open, output ready);
endinterface

// Register write channel
interface eng_csr_if;
   logic                               valid;
   logic                               ready;
   logic [eng_pkg::CSR_IDX_W-1:0]      index;
   logic [eng_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/eng_regs.sv
module eng_regs (
   input  logic             clock,
   input  logic             reset,
   eng_csr_if.sink          csr_port,
   output eng_pkg::cfg_type cfg
);

   eng_pkg::cfg_type cfg_ff;

   // Writes are always accepted
   assign csr_port.ready = 1'b1;
   assign cfg            = cfg_ff;

   // Register file; each write keeps the register's own width, unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_target      <= eng_pkg::RST_GAIN_TARGET;
         cfg_ff.open_threshold   <= eng_pkg::RST_OPEN_THRESHOLD;
         cfg_ff.close_threshold  <= eng_pkg::RST_CLOSE_THRESHOLD;
         cfg_ff.attack_coef      <= eng_pkg::RST_ATTACK_COEF;
         cfg_ff.release_coef     <= eng_pkg::RST_RELEASE_COEF;
         cfg_ff.gate_open_rate   <= eng_pkg::RST_GATE_OPEN_RATE;
         cfg_ff.gate_close_rate  <= eng_pkg::RST_GATE_CLOSE_RATE;
         cfg_ff.gain_smooth_rate <= eng_pkg::RST_GAIN_SMOOTH;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            eng_pkg::REG_GAIN_TARGET:
               cfg_ff.gain_target <= csr_port.data[eng_pkg::GAIN_W-1:0];
            eng_pkg::REG_OPEN_THRESHOLD:
               cfg_ff.open_threshold <= csr_port.data[eng_pkg::TH_W-1:0];
            eng_pkg::REG_CLOSE_THRESHOLD:
               cfg_ff.close_threshold <= csr_port.data[eng_pkg::TH_W-1:0];
            eng_pkg::REG_ATTACK_COEF:
               cfg_ff.attack_coef <= csr_port.data[eng_pkg::COEF_W-1:0];
            eng_pkg::REG_RELEASE_COEF:
               cfg_ff.release_coef <= csr_port.data[eng_pkg::COEF_W-1:0];
            eng_pkg::REG_GATE_OPEN_RATE:
               cfg_ff.gate_open_rate <= csr_port.data[eng_pkg::COEF_W-1:0];
            eng_pkg::REG_GATE_CLOSE_RATE:
               cfg_ff.gate_close_rate <= csr_port.data[eng_pkg::COEF_W-1:0];
            eng_pkg::REG_GAIN_SMOOTH:
               cfg_ff.gain_smooth_rate <= csr_port.data[eng_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

FILE: rtl/eng_mul.sv
module eng_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [eng_pkg::MUL_A_W-1:0]   a,
   input  logic [eng_pkg::MUL_B_W-1:0]   b,
   output logic                          busy,
   output logic [eng_pkg::MUL_P_W-1:0]   product
);

   localparam int AW = eng_pkg::MUL_A_W;
   localparam int BW = eng_pkg::MUL_B_W;
   localparam int PW = eng_pkg::MUL_P_W;

   logic [eng_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]                 a_ff;
   logic [PW-1:0]                 p_ff, p_in;
   logic [1:0]                    digit;
   logic [AW+1:0]                 partial;
   logic [AW+1:0]                 sum;

   // One radix-4 digit of b per cycle; b sits in the low end of p and shifts out
   assign digit   = p_ff[1:0];
   assign partial = (digit[0] ? {2'b00, a_ff} : '0) + (digit[1] ? {1'b0, a_ff, 1'b0} : '0);
   assign sum     = {2'b00, p_ff[PW-1:BW]} + partial;

   always_comb begin
      cnt_in = cnt_ff;
      p_in   = p_ff;
      if (start) begin
         cnt_in = eng_pkg::MUL_CNT_W'(eng_pkg::MUL_DIGITS);
         p_in   = {{AW{1'b0}}, b};
      end else if (busy) begin
         cnt_in = cnt_ff - eng_pkg::MUL_CNT_W'(1);
         p_in   = {sum, p_ff[BW-1:2]};
      end
   end

   assign busy    = (cnt_ff != '0);
   assign product = p_ff;

   // Digit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Operand and partial product registers
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
      end
      p_ff <= p_in;
   end

endmodule

FILE: rtl/envelope_noise_gate_core.sv
// A new sample is taken only in the idle state, once the previous result is loaded
//   into the output register, so an output stall holds off the next sample.
// Each sample makes five passes through one shared radix-4 serial
//   multiplier, plus a gate decision state and an output state.
// Reset: synchronous; envelope and gate gain clear, gate closed, smoothed
//   gain unity, registers at their default values.
module envelope_noise_gate_core (
   input  logic        clock,
   input  logic        reset,
   eng_req_if.sink     req_port,
   eng_rsp_if.source   rsp_port,
   eng_csr_if.sink     csr_port
);

   localparam int SW  = eng_pkg::SAMPLE_W;
   localparam int QW  = eng_pkg::Q_W;
   localparam int EW  = eng_pkg::ENV_W;
   localparam int PDW = eng_pkg::PROD_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_GATE  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   // Multiplier passes
   localparam logic [2:0] PH_ENV = 3'd0;
   localparam logic [2:0] PH_GG  = 3'd1;
   localparam logic [2:0] PH_SG  = 3'd2;
   localparam logic [2:0] PH_T1  = 3'd3;
   localparam logic [2:0] PH_T2  = 3'd4;

   eng_pkg::cfg_type cfg;

   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 ph_ff, ph_in;
   logic                       neg_ff;
   logic [SW-1:0]              mag_ff;
   logic                       up_ff;
   logic [EW-1:0]              env_ff;
   logic                       gate_ff;
   logic [eng_pkg::GG_W-1:0]   gg_ff;
   logic [eng_pkg::SG_W-1:0]   sg_ff;
   logic [PDW-1:0]             prod_ff;
   logic                       rsp_valid_ff;
   logic [SW-1:0]              sample_out_ff;
   logic                       gate_out_ff;

   logic                       accept;
   logic [SW-1:0]              raw;
   logic [SW-1:0]              mag_new;
   logic [EW-1:0]              cur;
   logic [EW-1:0]              tgt;
   logic [eng_pkg::COEF_W-1:0] coef;
   logic                       glide_up;
   logic [EW-1:0]              glide_d;
   logic [EW-1:0]              step_hi;
   logic                       step_nz;
   logic [EW-1:0]              glide_new;
   logic [PDW-1:0]             prod_new;
   logic [eng_pkg::CMP_W-1:0]  env_cmp;
   logic [eng_pkg::CMP_W-1:0]  open_cmp;
   logic [eng_pkg::CMP_W-1:0]  close_cmp;
   logic [SW-1:0]              sat_out;
   logic                       mul_start;
   logic                       mul_busy;
   logic                       out_load;
   logic [eng_pkg::MUL_A_W-1:0] mul_a;
   logic [eng_pkg::MUL_B_W-1:0] mul_b;
   logic [eng_pkg::MUL_P_W-1:0] mul_p;

   eng_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   eng_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   // Input handshake and magnitude
   assign req_port.ready = (state_ff == S_IDLE);
   assign accept         = req_port.valid && (state_ff == S_IDLE);
   assign raw            = req_port.sample_in;
   assign mag_new        = raw[SW-1] ? (~raw + SW'(1)) : raw;

   // Glide operands for the current pass
   always_comb begin
      unique case (ph_ff)
         PH_ENV: begin
            cur  = env_ff;
            tgt  = {mag_ff, {QW{1'b0}}};
            coef = ({mag_ff, {QW{1'b0}}} > env_ff) ? cfg.attack_coef : cfg.release_coef;
         end
         PH_GG: begin
            cur  = EW'(gg_ff);
            tgt  = gate_ff ? eng_pkg::ENV_ONE : '0;
            coef = gate_ff ? cfg.gate_open_rate : cfg.gate_close_rate;
         end
         PH_SG: begin
            cur  = EW'(sg_ff);
            tgt  = EW'(cfg.gain_target) << (eng_pkg::SG_W - eng_pkg::GAIN_W);
            coef = cfg.gain_smooth_rate;
         end
         default: begin
            cur  = '0;
            tgt  = '0;
            coef = cfg.gain_smooth_rate;
         end
      endcase
   end

   assign glide_up = (tgt > cur);
   assign glide_d  = glide_up ? (tgt - cur) : (cur - tgt);

   // Multiplier operands: distance times coefficient, or sample times gains
   always_comb begin
      unique case (ph_ff)
         PH_T1: begin
            mul_a = eng_pkg::MUL_A_W'(sg_ff);
            mul_b = eng_pkg::MUL_B_W'(mag_ff);
         end
         PH_T2: begin
            mul_a = eng_pkg::MUL_A_W'(prod_ff);
            mul_b = eng_pkg::MUL_B_W'(gg_ff);
         end
         default: begin
            mul_a = glide_d;
            mul_b = eng_pkg::MUL_B_W'(coef);
         end
      endcase
   end

   // Glide step rounded up: cur +/- (hi + any low bits), folded into one adder
   assign step_hi   = mul_p[QW +: EW];
   assign step_nz   = |mul_p[QW-1:0];
   assign glide_new = cur + (up_ff ? step_hi : ~step_hi)
                    + EW'(up_ff ? step_nz : !step_nz);
   assign prod_new  = mul_p[QW +: PDW];

   // Threshold compares on the scaled envelope
   assign env_cmp   = eng_pkg::CMP_W'(env_ff);
   assign open_cmp  = eng_pkg::CMP_W'(cfg.open_threshold) << QW;
   assign close_cmp = eng_pkg::CMP_W'(cfg.close_threshold) << QW;

   // Sign restore and saturation
   always_comb begin
      if (neg_ff) begin
         sat_out = (prod_ff > eng_pkg::NEG_LIM_MAG) ? eng_pkg::SAMPLE_MIN
                                                    : (~prod_ff[SW-1:0] + SW'(1));
      end else begin
         sat_out = (prod_ff > eng_pkg::POS_LIM_MAG) ? eng_pkg::SAMPLE_MAX
                                                    : prod_ff[SW-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      mul_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               state_in = S_SETUP;
               ph_in    = PH_ENV;
            end
         end
         S_SETUP: begin
            mul_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (!mul_busy) begin
               unique case (ph_ff)
                  PH_ENV: state_in = S_GATE;
                  PH_GG: begin
                     ph_in    = PH_SG;
                     state_in = S_SETUP;
                  end
                  PH_SG: begin
                     ph_in    = PH_T1;
                     state_in = S_SETUP;
                  end
                  PH_T1: begin
                     ph_in    = PH_T2;
                     state_in = S_SETUP;
                  end
                  PH_T2:   state_in = S_OUT;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_GATE: begin
            ph_in    = PH_GG;
            state_in = S_SETUP;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_ENV;
         env_ff       <= '0;
         gate_ff      <= 1'b0;
         gg_ff        <= '0;
         sg_ff        <= eng_pkg::SG_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         if (state_ff == S_WAIT && !mul_busy) begin
            unique case (ph_ff)
               PH_ENV:  env_ff <= glide_new;
               PH_GG:   gg_ff  <= glide_new[eng_pkg::GG_W-1:0];
               PH_SG:   sg_ff  <= glide_new[eng_pkg::SG_W-1:0];
               default: ;
            endcase
         end
         // Hysteresis gate on the new envelope
         if (state_ff == S_GATE) begin
            if (gate_ff) begin
               if (env_cmp < close_cmp) begin
                  gate_ff <= 1'b0;
               end
            end else if (env_cmp > open_cmp) begin
               gate_ff <= 1'b1;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-sample working registers and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff <= mag_new;
         neg_ff <= raw[SW-1];
      end
      if (state_ff == S_SETUP) begin
         up_ff <= glide_up;
      end
      if (state_ff == S_WAIT && !mul_busy && (ph_ff == PH_T1 || ph_ff == PH_T2)) begin
         prod_ff <= prod_new;
      end
      if (out_load) begin
         sample_out_ff <= sat_out;
         gate_out_ff   <= gate_ff;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.sample_out   = sample_out_ff;
   assign rsp_port.gate_is_open = gate_out_ff;

   // An accepted sample always begins with the envelope pass
   a_accept_starts_env : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SETUP && ph_ff == PH_ENV))
      else $error("accepted sample did not start the envelope pass");

   // The shared multiplier is never restarted mid-pass
   a_mul_no_overlap : assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   // Gate gain never glides past unity
   a_gg_bounded : assert property (@(posedge clock) disable iff (reset)
      gg_ff <= eng_pkg::GG_ONE)
      else $error("gate gain above unity");

   // Gate flag changes only in the gate decision cycle
   a_gate_from_decision : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && gate_ff != $past(gate_ff)) |-> $past(state_ff) == S_GATE)
      else $error("gate flag changed outside the gate decision");

   // A new result appears only from the output state
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff) == S_OUT)
      else $error("result valid raised outside the output state");

endmodule
